/* rtl/deq_pkg.sv */
// Shared constants, types and index helpers for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

   localparam int DEPTH        = 16;
   localparam int PAYLOAD_BITS = 32;

   localparam int MODE_W   = 3;
   localparam int KEY_W    = 32;
   localparam int FIELD_W  = 32;
   localparam int STATUS_W = 2;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int ENTRY_W  = KEY_W + PAYLOAD_BITS;

   // Request modes as they arrive on the port.
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIND       = 3'd4;

   // Internal operation codes after classification.
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NOP        = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd4;
   localparam logic [OP_W-1:0] OP_FIND       = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic signed [KEY_W-1:0] key;
      logic [PAYLOAD_BITS-1:0] payload;
   } cmd_type;

   // Slot at offset off from idx, modulo DEPTH; off never exceeds DEPTH.
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(idx) + (CNT_W+1)'(off);
      if (s >= (CNT_W+1)'(DEPTH)) begin
         s = s - (CNT_W+1)'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
   endfunction

   function automatic logic [PAYLOAD_BITS-1:0] to_store(input logic [FIELD_W-1:0] v);
      logic [FIELD_W+PAYLOAD_BITS-1:0] t;
      t = (FIELD_W+PAYLOAD_BITS)'(v);
      return t[PAYLOAD_BITS-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] from_store(input logic [PAYLOAD_BITS-1:0] v);
      logic [FIELD_W+PAYLOAD_BITS-1:0] t;
      t = (FIELD_W+PAYLOAD_BITS)'(v);
      return t[FIELD_W-1:0];
   endfunction

endpackage

/* rtl/deq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module deq_ram #(
   parameter int WIDTH = 8,
   parameter int WORDS = 16
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [(WORDS>1?$clog2(WORDS):1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                   wr_data,
   input  logic [(WORDS>1?$clog2(WORDS):1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                   rd_data
);

   logic [WIDTH-1:0] mem_ff [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/deq_front.sv */
// Request intake: classify the mode and buffer commands in a two-entry queue.
`timescale 1ns / 1ps

module deq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [deq_pkg::MODE_W-1:0]    req_mode,
   input  logic signed [deq_pkg::KEY_W-1:0] req_entry_key,
   input  logic [deq_pkg::FIELD_W-1:0]   req_entry_payload,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output deq_pkg::cmd_type              cmd
);
   import deq_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   cmd_type    new_cmd;
   logic       push, pop;

   always_comb begin
      new_cmd.key     = req_entry_key;
      new_cmd.payload = to_store(req_entry_payload);
      case (req_mode)
         MODE_PUSH_FRONT: new_cmd.op = OP_PUSH_FRONT;
         MODE_PUSH_REAR:  new_cmd.op = OP_PUSH_REAR;
         MODE_POP_FRONT:  new_cmd.op = OP_POP_FRONT;
         MODE_POP_REAR:   new_cmd.op = OP_POP_REAR;
         MODE_FIND:       new_cmd.op = OP_FIND;
         default:         new_cmd.op = OP_NOP;
      endcase
   end

   assign req_ready = (fill_ff != 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

/* rtl/deq_back.sv */
// Command execution: circular store, head index, count, key scan and result register.
`timescale 1ns / 1ps

module deq_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  deq_pkg::cmd_type                  cmd,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [deq_pkg::KEY_W-1:0]  rsp_out_key,
   output logic [deq_pkg::FIELD_W-1:0]       rsp_out_payload,
   output logic                              rsp_hit,
   output logic [deq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [deq_pkg::CNT_W-1:0]         rsp_entry_count
);
   import deq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_POP  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic             chk_ff, chk_in;
   logic [KEY_W-1:0] key_ff, key_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [FIELD_W-1:0]  rsp_pay_ff, rsp_pay_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic [KEY_W-1:0]   rd_key;
   logic [FIELD_W-1:0] rd_pay;

   logic load, res_hit, full, empty, take;
   logic [STATUS_W-1:0] res_status;

   deq_ram #(.WIDTH(ENTRY_W), .WORDS(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key  = rd_data[ENTRY_W-1 -: KEY_W];
   assign rd_pay  = from_store(rd_data[PAYLOAD_BITS-1:0]);
   assign wr_data = {cmd.key, cmd.payload};
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign take    = cmd_valid && cmd_ready;

   always_comb begin
      state_in   = state_ff;
      front_in   = front_ff;
      count_in   = count_ff;
      iss_in     = iss_ff;
      chk_in     = chk_ff;
      key_in     = key_ff;
      cmd_ready  = 1'b0;
      load       = 1'b0;
      res_hit    = 1'b0;
      res_status = STATUS_OK;
      wr_en      = 1'b0;
      wr_addr    = wrap_dec(front_ff);
      rd_addr    = wrap_add(front_ff, iss_ff);
      case (state_ff)
         ST_IDLE: begin
            cmd_ready = !rsp_valid_ff || rsp_ready;
            if (take) begin
               if (cmd.op inside {OP_PUSH_FRONT, OP_PUSH_REAR}) begin
                  load = 1'b1;
                  if (full) begin
                     res_status = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     if (cmd.op == OP_PUSH_FRONT || empty) begin
                        front_in = wrap_dec(front_ff);
                     end else begin
                        wr_addr = wrap_add(front_ff, count_ff);
                     end
                  end
               end else if (cmd.op inside {OP_POP_FRONT, OP_POP_REAR}) begin
                  if (empty) begin
                     load       = 1'b1;
                     res_status = STATUS_EMPTY;
                  end else begin
                     count_in = count_ff - 1'b1;
                     state_in = ST_POP;
                     if (cmd.op == OP_POP_FRONT) begin
                        rd_addr  = front_ff;
                        front_in = wrap_add(front_ff, CNT_W'(1));
                     end else begin
                        rd_addr = wrap_add(front_ff, count_ff - 1'b1);
                     end
                  end
               end else if (cmd.op == OP_FIND) begin
                  key_in = cmd.key;
                  if (empty) begin
                     load       = 1'b1;
                     res_status = STATUS_MISS;
                  end else begin
                     iss_in   = '0;
                     chk_in   = 1'b0;
                     state_in = ST_SCAN;
                  end
               end else begin
                  load = 1'b1;
               end
            end
         end
         ST_POP: begin
            load     = 1'b1;
            res_hit  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (chk_ff && rd_key == key_ff) begin
               load     = 1'b1;
               res_hit  = 1'b1;
               state_in = ST_IDLE;
            end else if (iss_ff == count_ff) begin
               load       = 1'b1;
               res_status = STATUS_MISS;
               state_in   = ST_IDLE;
            end else begin
               iss_in = iss_ff + 1'b1;
               chk_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_key_in    = rsp_key_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_key_in    = res_hit ? rd_key : '0;
         rsp_pay_in    = res_hit ? rd_pay : '0;
         rsp_hit_in    = res_hit;
         rsp_status_in = res_status;
         rsp_count_in  = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         iss_ff       <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         iss_ff       <= iss_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_payload = rsp_pay_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("held count above depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> iss_ff <= count_ff)
      else $error("scan offset past held records");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while waiting");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == ST_IDLE) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not advance count");

endmodule

/* rtl/double_ended_queue_with_key_search.sv */
// Top level of the bounded double-ended queue with key search.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Word
// req_      in         req_valid/ready    mode, entry_key, entry_payload
// rsp_      out        rsp_valid/ready    out_key, out_payload, hit, status, entry_count
//
// One word enters the front queue per cycle while req_ready is high; the back
// executes one command at a time. A pop waits on the registered store read;
// a find scans from the head, one store read port per cycle, until it reaches
// the first match or the held count.
// Reset clears head index, count, the front queue and the result valid; the store needs no clearing.
// A stalled rsp_ holds the result register and, once the front queue fills,
// drops req_ready; intake keeps running while the back works.

module double_ended_queue_with_key_search (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [deq_pkg::MODE_W-1:0]        req_mode,
   input  logic signed [deq_pkg::KEY_W-1:0]  req_entry_key,
   input  logic [deq_pkg::FIELD_W-1:0]       req_entry_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [deq_pkg::KEY_W-1:0]  rsp_out_key,
   output logic [deq_pkg::FIELD_W-1:0]       rsp_out_payload,
   output logic                              rsp_hit,
   output logic [deq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [deq_pkg::CNT_W-1:0]         rsp_entry_count
);
   import deq_pkg::*;

   // Classified command between intake and execution.
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_ready;

   // Intake: map the mode to an operation and buffer it.
   deq_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_entry_key     (req_entry_key),
      .req_entry_payload (req_entry_payload),
      .cmd_valid         (cmd_valid),
      .cmd_ready         (cmd_ready),
      .cmd               (cmd)
   );

   // Execution: update the circular store, scan for keys, hold the result.
   deq_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd             (cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_payload (rsp_out_payload),
      .rsp_hit         (rsp_hit),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

/* test/tb_double_ended_queue_with_key_search.sv */
// Self-checking testbench for the double-ended queue with key search.
`timescale 1ns / 1ps

module tb_double_ended_queue_with_key_search;
   import deq_pkg::*;

   // Modes past find are spare codes that the block must treat as no-ops.
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_FIND + 1'b1;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = '1;

   localparam int RANDOM_CMDS  = 1822;
   localparam int PHASE1_AT    = 620;      // words accepted before idle shares swap
   localparam int PHASE2_AT    = 1240;     // words accepted before idling stops
   localparam int HOLD_CYCLES  = 150;      // long receiver hold-off
   localparam int HOLD_SPACING = 1100;
   localparam int TAIL_CYCLES  = 40;       // longest find plus margin
   localparam int CYCLE_LIMIT  = 500000;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic signed [KEY_W-1:0] key;
      logic [FIELD_W-1:0]      payload;
      logic                    drain_first;   // wait for every result before offering
   } deque_cmd_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [FIELD_W-1:0]      payload;
      logic                    hit;
      logic [STATUS_W-1:0]     status;
      logic [CNT_W-1:0]        count;
   } deque_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [MODE_W-1:0]       req_mode = '0;
   logic signed [KEY_W-1:0] req_entry_key = '0;
   logic [FIELD_W-1:0]      req_entry_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [KEY_W-1:0] rsp_out_key;
   logic [FIELD_W-1:0]      rsp_out_payload;
   logic                    rsp_hit;
   logic [STATUS_W-1:0]     rsp_status;
   logic [CNT_W-1:0]        rsp_entry_count;

   double_ended_queue_with_key_search DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_entry_key     (req_entry_key),
      .req_entry_payload (req_entry_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_key       (rsp_out_key),
      .rsp_out_payload   (rsp_out_payload),
      .rsp_hit           (rsp_hit),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count)
   );

   // Commands waiting to be offered, and outcomes predicted but not yet seen.
   deque_cmd_type    cmd_q[$];
   deque_result_type outcome_q[$];
   deque_cmd_type    held_cmd;

   int cmds_taken    = 0;   // words accepted on req_
   int outcomes_seen = 0;   // words accepted on rsp_, updated at the edge
   int failures      = 0;
   int cycle_count   = 0;

   // Shadow copy of the deque: circular store, head slot and fill level.
   logic signed [KEY_W-1:0] shadow_key[DEPTH];
   logic [FIELD_W-1:0]      shadow_payload[DEPTH];
   int                      shadow_head  = 0;
   int                      shadow_count = 0;

   logic signed [KEY_W-1:0] key_pool[8];

   always #10 clock = ~clock;

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Apply one command to the shadow deque and return the outcome it must produce.
   function automatic deque_result_type apply_deque_op(input deque_cmd_type c);
      deque_result_type r;
      int               slot;
      int               i;
      bit               found;
      r     = '0;
      found = 1'b0;
      case (c.mode)
         MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
            if (shadow_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               // An empty deque always takes the new record at the head.
               if (c.mode == MODE_PUSH_FRONT || shadow_count == 0) begin
                  shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                  slot        = shadow_head;
               end else begin
                  slot = (shadow_head + shadow_count) % DEPTH;
               end
               shadow_key[slot]     = c.key;
               shadow_payload[slot] = c.payload;
               shadow_count++;
               r.status = STATUS_OK;
            end
         end
         MODE_POP_FRONT, MODE_POP_REAR: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               if (c.mode == MODE_POP_FRONT) begin
                  slot        = shadow_head;
                  shadow_head = (shadow_head + 1) % DEPTH;
               end else begin
                  slot = (shadow_head + shadow_count - 1) % DEPTH;
               end
               r.key     = shadow_key[slot];
               r.payload = shadow_payload[slot];
               r.hit     = 1'b1;
               r.status  = STATUS_OK;
               shadow_count--;
            end
         end
         MODE_FIND: begin
            // Walk from the head; the first matching key wins.
            r.status = STATUS_MISS;
            for (i = 0; i < shadow_count && !found; i++) begin
               slot = (shadow_head + i) % DEPTH;
               if (shadow_key[slot] == c.key) begin
                  found     = 1'b1;
                  r.key     = shadow_key[slot];
                  r.payload = shadow_payload[slot];
                  r.hit     = 1'b1;
                  r.status  = STATUS_OK;
               end
            end
         end
         default: begin
            r.status = STATUS_OK;
         end
      endcase
      r.count = CNT_W'(shadow_count);
      return r;
   endfunction

   // Idle share in percent for the sender (rx = 0) or the receiver (rx = 1).
   function automatic int idle_share(input int words_done, input bit rx);
      if (words_done < PHASE1_AT) begin
         return rx ? 54 : 17;
      end else if (words_done < PHASE2_AT) begin
         return rx ? 17 : 54;
      end
      return 0;
   endfunction

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         failures++;
      end
   endfunction

   task automatic queue_cmd(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                            input logic [FIELD_W-1:0] payload, input bit drain_first);
      deque_cmd_type c;
      c.mode        = mode;
      c.key         = key;
      c.payload     = payload;
      c.drain_first = drain_first;
      cmd_q.push_back(c);
   endtask

   // Sender: hold the word until taken, then predict it and maybe offer the next.
   always @(posedge clock) begin : sender
      deque_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            outcome_q.push_back(apply_deque_op(held_cmd));
            cmds_taken++;
         end
         if (!req_valid || req_ready) begin
            if (cmd_q.size() != 0
                && (!cmd_q[0].drain_first || cmds_taken == outcomes_seen)
                && $urandom_range(0, 99) >= idle_share(cmds_taken, 1'b0)) begin
               c                 = cmd_q.pop_front();
               held_cmd          = c;
               req_valid         <= 1'b1;
               req_mode          <= c.mode;
               req_entry_key     <= c.key;
               req_entry_payload <= c.payload;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: compare every accepted word with the oldest outcome, stall at random.
   int hold_left    = 0;
   int next_hold_at = 300;

   always @(posedge clock) begin : receiver
      deque_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            outcomes_seen <= outcomes_seen + 1;
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h %h %b %h %h", $time,
                        rsp_out_key, rsp_out_payload, rsp_hit, rsp_status, rsp_entry_count);
               failures++;
            end else begin
               want = outcome_q.pop_front();
               check_field("out_key", want.key, rsp_out_key);
               check_field("out_payload", want.payload, rsp_out_payload);
               check_field("hit", 32'(want.hit), 32'(rsp_hit));
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("entry_count", 32'(want.count), 32'(rsp_entry_count));
            end
         end
         // Long hold-off: the sender keeps offering, so the block backs up.
         if (hold_left == 0 && outcomes_seen >= next_hold_at) begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + HOLD_SPACING;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= idle_share(outcomes_seen, 1'b1));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                      n;
      int                      left;
      int                      bias;
      int                      roll;
      int                      push_share;
      int                      pop_share;
      logic [MODE_W-1:0]       mode;
      logic signed [KEY_W-1:0] key;

      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = '0;
      key_pool[3] = '1;
      for (n = 4; n < 8; n++) begin
         key_pool[n] = $urandom;
      end

      // Empty deque: pops and find report empty or miss; spare modes do nothing.
      queue_cmd(MODE_POP_FRONT, 32'h0, 32'h0, 1'b0);
      queue_cmd(MODE_POP_REAR, 32'h0, 32'h0, 1'b0);
      queue_cmd(MODE_FIND, 32'h0, 32'h0, 1'b0);
      queue_cmd(MODE_SPARE_LO, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
      queue_cmd(MODE_SPARE_HI, 32'h8000_0000, 32'hffff_ffff, 1'b0);
      // Rear push into an empty deque lands at the head.
      queue_cmd(MODE_PUSH_REAR, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);
      queue_cmd(MODE_PUSH_FRONT, 32'h8000_0000, 32'h0, 1'b0);
      queue_cmd(MODE_PUSH_REAR, 32'hffff_ffff, 32'ha5a5_a5a5, 1'b0);
      queue_cmd(MODE_FIND, 32'hffff_ffff, 32'h0, 1'b0);
      queue_cmd(MODE_FIND, 32'd12345, 32'h0, 1'b0);
      // Fill to the brim, the last record at the rear carrying a unique key.
      for (n = 0; n < DEPTH - 4; n++) begin
         queue_cmd(n[0] ? MODE_PUSH_REAR : MODE_PUSH_FRONT, key_pool[4 + n % 4],
                   $urandom, 1'b0);
      end
      queue_cmd(MODE_PUSH_REAR, 32'h1234_5678, 32'h5a5a_5a5a, 1'b0);
      queue_cmd(MODE_PUSH_FRONT, 32'h1, 32'h1, 1'b0);
      queue_cmd(MODE_PUSH_REAR, 32'h2, 32'h2, 1'b0);
      queue_cmd(MODE_FIND, 32'h1234_5678, 32'h0, 1'b0);
      queue_cmd(MODE_POP_FRONT, 32'h0, 32'h0, 1'b0);
      queue_cmd(MODE_POP_REAR, 32'h0, 32'h0, 1'b0);

      // Random bursts that lean toward filling, draining or neither.
      left = 0;
      bias = 0;
      for (n = 0; n < RANDOM_CMDS; n++) begin
         if (left == 0) begin
            bias = $urandom_range(0, 2);
            left = $urandom_range(8, 40);
         end
         left--;
         push_share = (bias == 0) ? 60 : (bias == 1) ? 15 : 35;
         pop_share  = (bias == 0) ? 15 : (bias == 1) ? 60 : 35;
         roll       = $urandom_range(0, 99);
         if (roll < push_share) begin
            mode = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
         end else if (roll < push_share + pop_share) begin
            mode = $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
         end else if (roll < 96) begin
            mode = MODE_FIND;
         end else begin
            mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
         end
         // Draw keys mostly from a small pool so finds hit often.
         key = ($urandom_range(0, 99) < 78) ? key_pool[$urandom_range(0, 7)] : $urandom;
         queue_cmd(mode, key, $urandom, (n % 300) == 150);
      end

      wait (!reset);
      while (cmd_q.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (outcomes_seen != cmds_taken) begin
         @(posedge clock);
      end
      // Give a stray extra word time to show up.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (outcome_q.size() != 0) begin
         $display("%0t: %0d outcomes never arrived, expected none left, actual %0d",
                  $time, outcome_q.size(), outcome_q.size());
         failures = failures + outcome_q.size();
      end
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_front.sv
rtl/deq_back.sv
rtl/double_ended_queue_with_key_search.sv
test/tb_double_ended_queue_with_key_search.sv
